// ===== rtl/rle_sprite_line_decoder_unit_macros.svh =====
// Assertion macros used by the sprite line decoder RTL.
`ifndef RLE_SPRITE_LINE_DECODER_UNIT_MACROS_SVH
`define RLE_SPRITE_LINE_DECODER_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RSLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RSLD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsld_pkg.sv =====
// Types, constants and field widths for the sprite line decoder.
package rsld_pkg;

    localparam int LINE_WIDTH = 1024;
    localparam int XW         = $clog2(LINE_WIDTH);
    localparam int REM_W      = XW + 1;

    localparam int WORD_W     = 16;
    localparam int CURSOR_W   = 16;
    localparam int LEN_W      = 7;
    localparam int XPOS_W     = 10;
    localparam int KIND_W     = 2;

    localparam int HDR_FILL_LSB = 9;
    localparam int HDR_SKIP_BIT = 8;
    localparam int HDR_EOL_BIT  = 7;

    localparam int TDATA_OUT_W  = 40;
    localparam int TDATA_OUT_PAD = TDATA_OUT_W - (XPOS_W + LEN_W + WORD_W);

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_PIXEL = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_COLOUR = 3'b010,
        PH_PIXEL  = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [CURSOR_W-1:0] cursor;
        logic [LEN_W-1:0]    pending;
        logic [LEN_W-1:0]    copy_left;
        logic                eol;
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [XPOS_W-1:0] x_pos;
        logic [LEN_W-1:0]  run_length;
        logic [WORD_W-1:0] colour;
        logic              line_done;
    } t_result;

endpackage

// ===== rtl/rle_sprite_line_decoder_unit.sv =====
// Top level of the run-length sprite line decoder: input, state and result registers.
// A word is held in the input register, decoded, and presented from the result register.
// Throughput: one word per cycle unless stalled; the only loop is the parser state register.
// Each request yields exactly one result; with both registers full, slave ready follows master ready.
// Reset (synchronous, active low) clears valids, counts, cursor and start_x; a header is expected.
// The start position register is written at any time and used at the next cursor reload.
`include "rle_sprite_line_decoder_unit_macros.svh"

module rle_sprite_line_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // start_x (signed)
    // Slave stream side.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,      // [15:0] stream_word
    input  logic [0:0]  i_s_tuser,      // [0] restart_line
    // Master stream side.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,      // [9:0] x_pos, [16:10] run_length, [32:17] pixel_colour
    output logic [1:0]  o_m_tuser,      // [1:0] draw_kind
    output logic        o_m_tlast       // line_done
);

    logic [rsld_pkg::CURSOR_W-1:0] r_start_x;
    logic                          r_in_valid;
    logic [rsld_pkg::WORD_W-1:0]   r_in_word;
    logic                          r_in_restart;
    rsld_pkg::t_state              r_state;
    rsld_pkg::t_state              n_state;
    logic                          r_out_valid;
    rsld_pkg::t_result             r_out;
    rsld_pkg::t_result             n_out;
    logic [rsld_pkg::CURSOR_W-1:0] line_start;
    logic                          advance;

    assign o_cfg_ready = 1'b1;
    assign line_start  = r_start_x[rsld_pkg::CURSOR_W-1] ? '0 : r_start_x;
    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;

    rsld_step u_step (
        .i_state      (r_state),
        .i_word       (r_in_word),
        .i_restart    (r_in_restart),
        .i_line_start (line_start),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_start_x <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_word    <= i_s_tdata;
            r_in_restart <= i_s_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= rsld_pkg::PH_HEADER;
            r_state.cursor    <= '0;
            r_state.pending   <= '0;
            r_state.copy_left <= '0;
            r_state.eol       <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.line_done;
    assign o_m_tdata  = {{rsld_pkg::TDATA_OUT_PAD{1'b0}}, r_out.colour,
                         r_out.run_length, r_out.x_pos};

    `RSLD_ASSERT_IMPL(a_none_is_empty,
        r_out_valid && r_out.kind == rsld_pkg::KIND_NONE,
        r_out.run_length == '0 && r_out.x_pos == '0 && r_out.colour == '0,
        "empty result carries nonzero payload")
    `RSLD_ASSERT_IMPL(a_draw_in_line,
        r_out_valid && r_out.kind != rsld_pkg::KIND_NONE,
        r_out.run_length != '0 &&
        ({1'b0, r_out.x_pos} + 11'(r_out.run_length)) <= 11'(rsld_pkg::LINE_WIDTH),
        "draw result is empty or runs past the line")
    `RSLD_ASSERT_IMPL(a_header_clean,
        r_state.phase == rsld_pkg::PH_HEADER,
        r_state.copy_left == '0 && r_state.pending == '0 && !r_state.eol,
        "record state left over while waiting for a header")
    `RSLD_ASSERT_IMPL(a_pixel_has_count,
        r_state.phase == rsld_pkg::PH_PIXEL,
        r_state.copy_left != '0,
        "pixel phase with no pixels left")

endmodule

// ===== rtl/rsld_step.sv =====
// Combinational decode of one stream word: next parser state and draw result.
module rsld_step (
    input  rsld_pkg::t_state                  i_state,
    input  logic [rsld_pkg::WORD_W-1:0]       i_word,
    input  logic                              i_restart,
    input  logic [rsld_pkg::CURSOR_W-1:0]     i_line_start,
    output rsld_pkg::t_state                  o_state,
    output rsld_pkg::t_result                 o_result
);

    rsld_pkg::t_phase                  ph;
    logic [rsld_pkg::CURSOR_W-1:0]     cur;
    logic [rsld_pkg::LEN_W-1:0]        adv_n;
    logic [rsld_pkg::CURSOR_W:0]       adv_sum;
    logic [rsld_pkg::CURSOR_W-1:0]     cur_adv;
    rsld_pkg::t_kind                   emit_kind;
    logic [rsld_pkg::LEN_W-1:0]        emit_len;
    logic                              finish;
    logic [rsld_pkg::LEN_W-1:0]        copy_next;
    logic [rsld_pkg::LEN_W-1:0]        pend_next;
    logic                              eol_next;
    rsld_pkg::t_phase                  ph_next;
    logic [rsld_pkg::REM_W-1:0]        remaining;
    logic                              in_line;

    always_comb begin
        cur = i_restart ? i_line_start : i_state.cursor;
        ph  = i_restart ? rsld_pkg::PH_HEADER : i_state.phase;

        emit_kind = rsld_pkg::KIND_NONE;
        emit_len  = '0;
        adv_n     = '0;
        finish    = 1'b0;
        copy_next = i_state.copy_left;
        pend_next = i_state.pending;
        eol_next  = i_state.eol;
        ph_next   = ph;

        unique case (ph)
            rsld_pkg::PH_COLOUR: begin
                emit_kind = rsld_pkg::KIND_FILL;
                emit_len  = i_state.pending;
                adv_n     = i_state.pending;
                pend_next = '0;
                if (i_state.copy_left != '0) begin
                    ph_next = rsld_pkg::PH_PIXEL;
                end else begin
                    finish = 1'b1;
                end
            end
            rsld_pkg::PH_PIXEL: begin
                emit_kind = rsld_pkg::KIND_PIXEL;
                emit_len  = rsld_pkg::LEN_W'(1);
                adv_n     = rsld_pkg::LEN_W'(1);
                copy_next = i_state.copy_left - rsld_pkg::LEN_W'(1);
                if (copy_next == '0) begin
                    finish = 1'b1;
                end
            end
            default: begin
                // Header word: fill length, skip, end-of-line flag, copy count.
                eol_next  = i_word[rsld_pkg::HDR_EOL_BIT];
                copy_next = i_word[rsld_pkg::LEN_W-1:0];
                if (!i_word[rsld_pkg::HDR_SKIP_BIT]) begin
                    pend_next = i_word[rsld_pkg::HDR_FILL_LSB +: rsld_pkg::LEN_W];
                    ph_next   = rsld_pkg::PH_COLOUR;
                end else begin
                    pend_next = '0;
                    adv_n     = i_word[rsld_pkg::HDR_FILL_LSB +: rsld_pkg::LEN_W];
                    if (copy_next != '0) begin
                        ph_next = rsld_pkg::PH_PIXEL;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
        endcase

        // Cursor saturates at the top of its range.
        adv_sum = {1'b0, cur} + (rsld_pkg::CURSOR_W + 1)'(adv_n);
        cur_adv = adv_sum[rsld_pkg::CURSOR_W] ? '1 : adv_sum[rsld_pkg::CURSOR_W-1:0];

        o_result.line_done = finish & eol_next;

        o_state.cursor    = cur_adv;
        o_state.phase     = ph_next;
        o_state.copy_left = copy_next;
        o_state.pending   = pend_next;
        o_state.eol       = eol_next;
        if (finish) begin
            o_state.phase     = rsld_pkg::PH_HEADER;
            o_state.copy_left = '0;
            o_state.pending   = '0;
            o_state.eol       = 1'b0;
            if (eol_next) begin
                o_state.cursor = i_line_start;
            end
        end

        // Clip the draw against the right edge of the line.
        in_line   = cur < rsld_pkg::CURSOR_W'(rsld_pkg::LINE_WIDTH);
        remaining = rsld_pkg::REM_W'(rsld_pkg::LINE_WIDTH)
                  - rsld_pkg::REM_W'(cur[rsld_pkg::XW-1:0]);

        if (emit_kind != rsld_pkg::KIND_NONE && emit_len != '0 && in_line) begin
            o_result.kind       = emit_kind;
            o_result.x_pos      = rsld_pkg::XPOS_W'(cur[rsld_pkg::XW-1:0]);
            o_result.run_length = (rsld_pkg::REM_W'(emit_len) > remaining)
                                ? remaining[rsld_pkg::LEN_W-1:0] : emit_len;
            o_result.colour     = i_word;
        end else begin
            o_result.kind       = rsld_pkg::KIND_NONE;
            o_result.x_pos      = '0;
            o_result.run_length = '0;
            o_result.colour     = '0;
        end
    end

endmodule
